@@ hdl/ls3_pkg.sv @@
`timescale 1ns / 1ps

package ls3_pkg;

	localparam int DW            = 32;
	localparam int FRAC_BITS_DEF = 16;
	// wide enough for a full product or a full divider quotient
	localparam int MAG_W         = 3 * DW;

	typedef logic signed [DW-1:0] fix_t;

	typedef struct packed {
		fix_t m00;
		fix_t m10;
		fix_t m20;
		fix_t m11;
		fix_t m21;
		fix_t m22;
		fix_t rhs_x;
		fix_t rhs_y;
		fix_t rhs_z;
	} ls3_in_t;

	typedef struct packed {
		fix_t sol_x;
		fix_t sol_y;
		fix_t sol_z;
		logic singular;
	} ls3_out_t;

	typedef struct packed {
		fix_t v;
		logic f;
	} res_t;

	// everything one system carries down the pipe
	typedef struct packed {
		fix_t a11, a21, a22, d1, y1, by, bz;
		fix_t l21, l31, z1;
		fix_t m1, m2, m3, p1, p2;
		fix_t m1d, m2d, m3d, y2, s;
		fix_t d2, u, l32, z2;
		fix_t n1, n2, n1d, y3, t, d3;
		fix_t x2, q, r, x1, w, e;
		logic flg;
	} ctx_t;

	function automatic logic [DW-1:0] mag(input fix_t v);
		mag = v[DW-1] ? -v : v;
	endfunction

	function automatic res_t sat_mag(input logic [MAG_W-1:0] m, input logic neg);
		logic [MAG_W-1:0] lim;
		logic [MAG_W-1:0] mm;
		res_t res;
		lim = MAG_W'(1) << (DW - 1);
		if (!neg) begin
			lim = lim - MAG_W'(1);
		end
		res.f = m > lim;
		mm = res.f ? lim : m;
		res.v = neg ? -fix_t'(mm[DW-1:0]) : fix_t'(mm[DW-1:0]);
		return res;
	endfunction

	function automatic res_t clamp_sum(input logic [DW:0] sm);
		res_t res;
		res.f = sm[DW] ^ sm[DW-1];
		if (res.f) begin
			res.v = sm[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			res.v = sm[DW-1:0];
		end
		return res;
	endfunction

	function automatic res_t fx_add(input fix_t a, input fix_t b);
		return clamp_sum({a[DW-1], a} + {b[DW-1], b});
	endfunction

	function automatic res_t fx_sub(input fix_t a, input fix_t b);
		return clamp_sum({a[DW-1], a} - {b[DW-1], b});
	endfunction

	function automatic res_t fx_mul(input fix_t a, input fix_t b, input int frac);
		logic [2*DW-1:0] p;
		p = (2*DW)'(mag(a)) * (2*DW)'(mag(b));
		return sat_mag(MAG_W'(p >> frac), a[DW-1] ^ b[DW-1]);
	endfunction

	// three dividers of DW+frac+2 stages plus twelve arithmetic stages
	function automatic int ls3_latency(input int frac);
		return 3 * (DW + frac + 2) + 12;
	endfunction

endpackage

@@ hdl/ls3_div.sv @@
`timescale 1ns / 1ps

module ls3_div import ls3_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int LANES     = 1,
	parameter int SIDE_W    = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  fix_t              num [LANES],
	input  fix_t              den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output fix_t              quo [LANES],
	output logic              out_flag,
	output logic [SIDE_W-1:0] side_out
);

	localparam int NB = DW + FRAC_BITS;
	localparam int RW = DW + 1;

	logic [NB:0]        vld_s;
	logic [SIDE_W-1:0]  side_s [0:NB];
	logic [DW-1:0]      ud_s   [0:NB];
	logic [LANES-1:0]   neg_s  [0:NB];
	// dividend shifts out at the top, quotient bits shift in at the bottom
	logic [NB-1:0]      dvd_s  [0:NB][0:LANES-1];
	logic [RW-1:0]      rem_s  [0:NB][0:LANES-1];

	logic [RW-1:0]      trial  [1:NB][0:LANES-1];
	logic [LANES-1:0]   ge     [1:NB];
	res_t               fin    [0:LANES-1];
	logic               vld_o_s;
	logic [LANES-1:0]   flag_o_s;

	always_comb begin
		for (int k = 1; k <= NB; k++) begin
			for (int l = 0; l < LANES; l++) begin
				trial[k][l] = {rem_s[k-1][l][RW-2:0], dvd_s[k-1][l][NB-1]};
				ge[k][l]    = trial[k][l] >= {1'b0, ud_s[k-1]};
			end
		end
		for (int l = 0; l < LANES; l++) begin
			fin[l] = sat_mag(MAG_W'(dvd_s[NB][l]), neg_s[NB][l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			vld_o_s <= 1'b0;
		end else begin
			vld_s   <= {vld_s[NB-1:0], in_valid};
			vld_o_s <= vld_s[NB];
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side_in;
		ud_s[0]   <= mag(den);
		for (int l = 0; l < LANES; l++) begin
			neg_s[0][l] <= num[l][DW-1] ^ den[DW-1];
			dvd_s[0][l] <= NB'(mag(num[l])) << FRAC_BITS;
			rem_s[0][l] <= '0;
		end
		for (int k = 1; k <= NB; k++) begin
			side_s[k] <= side_s[k-1];
			ud_s[k]   <= ud_s[k-1];
			neg_s[k]  <= neg_s[k-1];
			for (int l = 0; l < LANES; l++) begin
				rem_s[k][l] <= ge[k][l] ? trial[k][l] - {1'b0, ud_s[k-1]} : trial[k][l];
				dvd_s[k][l] <= {dvd_s[k-1][l][NB-2:0], ge[k][l]};
			end
		end
		side_out <= side_s[NB];
		for (int l = 0; l < LANES; l++) begin
			quo[l]      <= fin[l].v;
			flag_o_s[l] <= fin[l].f;
		end
	end

	assign out_valid = vld_o_s;
	assign out_flag  = |flag_o_s;

endmodule

@@ hdl/ldlt_solve_3x3.sv @@
`timescale 1ns / 1ps

// symmetric 3x3 solver: factors A = L D L^T, then forward, diagonal and
// back substitution, all in signed fixed point with saturation.
// input channel: drive operands and raise start; a word is taken at every
// rising edge with start high and busy low. busy stays low, so a new system
// can enter on every cycle.
// output channel: done is high for one cycle with result holding x and the
// singular flag; the receiver has no way to hold it, it must take it then.
// the pipe is built from three pipelined restoring dividers in series, one
// quotient bit per stage, for the first pivot, the second pivot and the
// third pivot; registered stages of multiplies, adds and subtracts lie
// between them and after the third, the last one being the result register.
// throughput: one system per cycle, results leave in order of entry.
// reset: clears every valid bit and the result register; systems in flight
// are dropped and done stays low until new work has come through.

module ldlt_solve_3x3 import ls3_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  ls3_in_t  operands,
	output logic     done,
	output ls3_out_t result
);

	localparam int CW = $bits(ctx_t);

	// first pivot: l21, l31 and z1 share divisor d1
	ctx_t c0;
	fix_t na [3];
	fix_t qa [3];
	logic va, fa;
	logic [CW-1:0] sa;
	ctx_t ca;

	always_comb begin
		c0     = '0;
		c0.a11 = operands.m11;
		c0.a21 = operands.m21;
		c0.a22 = operands.m22;
		c0.d1  = operands.m00;
		c0.y1  = operands.rhs_x;
		c0.by  = operands.rhs_y;
		c0.bz  = operands.rhs_z;
	end

	assign na[0] = operands.m10;
	assign na[1] = operands.m20;
	assign na[2] = operands.rhs_x;

	ls3_div #(.FRAC_BITS(FRAC_BITS), .LANES(3), .SIDE_W(CW)) u_div_a (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy),
		.num(na), .den(operands.m00), .side_in(c0),
		.out_valid(va), .quo(qa), .out_flag(fa), .side_out(sa)
	);

	always_comb begin
		ca     = ctx_t'(sa);
		ca.l21 = qa[0];
		ca.l31 = qa[1];
		ca.z1  = qa[2];
		ca.flg = ca.flg | fa;
	end

	// stage 2
	res_t r2_m1, r2_m2, r2_m3, r2_p1, r2_p2;
	ctx_t n2, c2_s;
	logic v2_s;
	assign r2_m1 = fx_mul(ca.l21, ca.l21, FRAC_BITS);
	assign r2_m2 = fx_mul(ca.l21, ca.l31, FRAC_BITS);
	assign r2_m3 = fx_mul(ca.l31, ca.l31, FRAC_BITS);
	assign r2_p1 = fx_mul(ca.l21, ca.y1, FRAC_BITS);
	assign r2_p2 = fx_mul(ca.l31, ca.y1, FRAC_BITS);
	always_comb begin
		n2     = ca;
		n2.m1  = r2_m1.v;
		n2.m2  = r2_m2.v;
		n2.m3  = r2_m3.v;
		n2.p1  = r2_p1.v;
		n2.p2  = r2_p2.v;
		n2.flg = ca.flg | r2_m1.f | r2_m2.f | r2_m3.f | r2_p1.f | r2_p2.f;
	end

	// stage 3
	res_t r3_a, r3_b, r3_c, r3_y2, r3_s;
	ctx_t n3, c3_s;
	logic v3_s;
	assign r3_a  = fx_mul(c2_s.m1, c2_s.d1, FRAC_BITS);
	assign r3_b  = fx_mul(c2_s.m2, c2_s.d1, FRAC_BITS);
	assign r3_c  = fx_mul(c2_s.m3, c2_s.d1, FRAC_BITS);
	assign r3_y2 = fx_sub(c2_s.by, c2_s.p1);
	assign r3_s  = fx_sub(c2_s.bz, c2_s.p2);
	always_comb begin
		n3     = c2_s;
		n3.m1d = r3_a.v;
		n3.m2d = r3_b.v;
		n3.m3d = r3_c.v;
		n3.y2  = r3_y2.v;
		n3.s   = r3_s.v;
		n3.flg = c2_s.flg | r3_a.f | r3_b.f | r3_c.f | r3_y2.f | r3_s.f;
	end

	// stage 4: second pivot and numerator of l32
	res_t r4_d2, r4_u;
	ctx_t n4, c4_s;
	logic v4_s;
	assign r4_d2 = fx_sub(c3_s.a11, c3_s.m1d);
	assign r4_u  = fx_sub(c3_s.a21, c3_s.m2d);
	always_comb begin
		n4     = c3_s;
		n4.d2  = r4_d2.v;
		n4.u   = r4_u.v;
		n4.flg = c3_s.flg | r4_d2.f | r4_u.f;
	end

	fix_t nb [2];
	fix_t qb [2];
	logic vb, fb;
	logic [CW-1:0] sb;
	ctx_t cb;
	assign nb[0] = c4_s.u;
	assign nb[1] = c4_s.y2;

	ls3_div #(.FRAC_BITS(FRAC_BITS), .LANES(2), .SIDE_W(CW)) u_div_b (
		.clk(clk), .arst_n(arst_n), .in_valid(v4_s),
		.num(nb), .den(c4_s.d2), .side_in(c4_s),
		.out_valid(vb), .quo(qb), .out_flag(fb), .side_out(sb)
	);

	always_comb begin
		cb     = ctx_t'(sb);
		cb.l32 = qb[0];
		cb.z2  = qb[1];
		cb.flg = cb.flg | fb;
	end

	// stage 6
	res_t r6_n1, r6_n2;
	ctx_t n6, c6_s;
	logic v6_s;
	assign r6_n1 = fx_mul(cb.l32, cb.l32, FRAC_BITS);
	assign r6_n2 = fx_mul(cb.l32, cb.y2, FRAC_BITS);
	always_comb begin
		n6     = cb;
		n6.n1  = r6_n1.v;
		n6.n2  = r6_n2.v;
		n6.flg = cb.flg | r6_n1.f | r6_n2.f;
	end

	// stage 7
	res_t r7_n1d, r7_y3;
	ctx_t n7, c7_s;
	logic v7_s;
	assign r7_n1d = fx_mul(c6_s.n1, c6_s.d2, FRAC_BITS);
	assign r7_y3  = fx_sub(c6_s.s, c6_s.n2);
	always_comb begin
		n7     = c6_s;
		n7.n1d = r7_n1d.v;
		n7.y3  = r7_y3.v;
		n7.flg = c6_s.flg | r7_n1d.f | r7_y3.f;
	end

	// stage 8
	res_t r8_t;
	ctx_t n8, c8_s;
	logic v8_s;
	assign r8_t = fx_add(c7_s.m3d, c7_s.n1d);
	always_comb begin
		n8     = c7_s;
		n8.t   = r8_t.v;
		n8.flg = c7_s.flg | r8_t.f;
	end

	// stage 9: third pivot
	res_t r9_d3;
	ctx_t n9, c9_s;
	logic v9_s;
	assign r9_d3 = fx_sub(c8_s.a22, c8_s.t);
	always_comb begin
		n9     = c8_s;
		n9.d3  = r9_d3.v;
		n9.flg = c8_s.flg | r9_d3.f;
	end

	fix_t nc [1];
	fix_t qc [1];
	logic vc, fc;
	logic [CW-1:0] sc;
	ctx_t cc;
	assign nc[0] = c9_s.y3;

	ls3_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .SIDE_W(CW)) u_div_c (
		.clk(clk), .arst_n(arst_n), .in_valid(v9_s),
		.num(nc), .den(c9_s.d3), .side_in(c9_s),
		.out_valid(vc), .quo(qc), .out_flag(fc), .side_out(sc)
	);

	always_comb begin
		cc     = ctx_t'(sc);
		cc.x2  = qc[0];
		cc.flg = cc.flg | fc;
	end

	// stage 11: back substitution
	res_t r11_q, r11_r;
	ctx_t n11, c11_s;
	logic v11_s;
	assign r11_q = fx_mul(cc.l32, cc.x2, FRAC_BITS);
	assign r11_r = fx_mul(cc.l31, cc.x2, FRAC_BITS);
	always_comb begin
		n11     = cc;
		n11.q   = r11_q.v;
		n11.r   = r11_r.v;
		n11.flg = cc.flg | r11_q.f | r11_r.f;
	end

	// stage 12
	res_t r12_x1;
	ctx_t n12, c12_s;
	logic v12_s;
	assign r12_x1 = fx_sub(c11_s.z2, c11_s.q);
	always_comb begin
		n12     = c11_s;
		n12.x1  = r12_x1.v;
		n12.flg = c11_s.flg | r12_x1.f;
	end

	// stage 13
	res_t r13_w;
	ctx_t n13, c13_s;
	logic v13_s;
	assign r13_w = fx_mul(c12_s.l21, c12_s.x1, FRAC_BITS);
	always_comb begin
		n13     = c12_s;
		n13.w   = r13_w.v;
		n13.flg = c12_s.flg | r13_w.f;
	end

	// stage 14
	res_t r14_e;
	ctx_t n14, c14_s;
	logic v14_s;
	assign r14_e = fx_sub(c13_s.z1, c13_s.w);
	always_comb begin
		n14     = c13_s;
		n14.e   = r14_e.v;
		n14.flg = c13_s.flg | r14_e.f;
	end

	// output stage
	res_t     r15_x0;
	ls3_out_t res_n;
	ls3_out_t res_q;
	logic     done_q;
	assign r15_x0 = fx_sub(c14_s.e, c14_s.r);
	always_comb begin
		res_n.sol_x    = r15_x0.v;
		res_n.sol_y    = c14_s.x1;
		res_n.sol_z    = c14_s.x2;
		res_n.singular = c14_s.flg | r15_x0.f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s   <= 1'b0;
			v3_s   <= 1'b0;
			v4_s   <= 1'b0;
			v6_s   <= 1'b0;
			v7_s   <= 1'b0;
			v8_s   <= 1'b0;
			v9_s   <= 1'b0;
			v11_s  <= 1'b0;
			v12_s  <= 1'b0;
			v13_s  <= 1'b0;
			v14_s  <= 1'b0;
			done_q <= 1'b0;
			res_q  <= '0;
		end else begin
			v2_s   <= va;
			v3_s   <= v2_s;
			v4_s   <= v3_s;
			v6_s   <= vb;
			v7_s   <= v6_s;
			v8_s   <= v7_s;
			v9_s   <= v8_s;
			v11_s  <= vc;
			v12_s  <= v11_s;
			v13_s  <= v12_s;
			v14_s  <= v13_s;
			done_q <= v14_s;
			if (v14_s) begin
				res_q <= res_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		c2_s  <= n2;
		c3_s  <= n3;
		c4_s  <= n4;
		c6_s  <= n6;
		c7_s  <= n7;
		c8_s  <= n8;
		c9_s  <= n9;
		c11_s <= n11;
		c12_s <= n12;
		c13_s <= n13;
		c14_s <= n14;
	end

	// the pipe never holds back, a word can enter every cycle
	assign busy   = 1'b0;
	assign done   = done_q;
	assign result = res_q;

endmodule

@@ hdl/ls3_check.sv @@
`timescale 1ns / 1ps

module ls3_check import ls3_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input ls3_in_t  operands,
	input logic     done,
	input ls3_out_t result
);

	localparam int LAT = ls3_latency(FRAC_BITS);
	localparam int CNW = $clog2(LAT + 1);

	// cycles since reset, saturating once the pipe has filled
	logic [CNW-1:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (fill_q != CNW'(LAT)) begin
			fill_q <= fill_q + CNW'(1);
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == CNW'(LAT)) |-> (done == $past(start && !busy, LAT)))
		else $error("result word not at fixed latency");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != CNW'(LAT)) |-> !done)
		else $error("result word before pipe could fill");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != '0 && !done) |-> $stable(result))
		else $error("result changed without strobe");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind ldlt_solve_3x3 ls3_check #(.FRAC_BITS(FRAC_BITS)) u_ls3_check (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.operands(operands), .done(done), .result(result)
);

@@ verif/ldlt_solve_3x3_checker.sv @@
`timescale 1ns / 1ps

module ldlt_solve_3x3_checker import ls3_pkg::*; #(
	parameter int FRAC = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  ls3_in_t  operands,
	input  logic     done,
	input  ls3_out_t result,
	output int       fail_count,
	output int       pending
);

	localparam longint VMAX = (64'sd1 <<< (DW - 1)) - 1;
	localparam longint VMIN = -VMAX - 1;

	ls3_out_t solution_q[$];
	bit       sat;

	assign pending = solution_q.size();

	function automatic longint clip(input longint v);
		if (v > VMAX) begin
			sat = 1;
			return VMAX;
		end
		if (v < VMIN) begin
			sat = 1;
			return VMIN;
		end
		return v;
	endfunction

	function automatic longint q_add(input longint a, input longint b);
		return clip(a + b);
	endfunction

	function automatic longint q_sub(input longint a, input longint b);
		return clip(a - b);
	endfunction

	// magnitudes fit in 64 bits, shift on the magnitude truncates toward zero
	function automatic longint q_mul(input longint a, input longint b);
		logic [127:0] p;
		logic [127:0] m;
		bit neg;
		neg = (a < 0) != (b < 0);
		p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
		m = p >> FRAC;
		if (m > 128'(VMAX) + (neg ? 1 : 0)) begin
			sat = 1;
			return neg ? VMIN : VMAX;
		end
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint q_div(input longint n, input longint d);
		logic [127:0] num;
		logic [127:0] qt;
		bit neg;
		if (d == 0) begin
			sat = 1;
			return n >= 0 ? VMAX : VMIN;
		end
		neg = (n < 0) != (d < 0);
		num = 128'(n < 0 ? -n : n) << FRAC;
		qt = num / 128'(d < 0 ? -d : d);
		if (qt > 128'(VMAX) + (neg ? 1 : 0)) begin
			sat = 1;
			return neg ? VMIN : VMAX;
		end
		return neg ? -longint'(qt) : longint'(qt);
	endfunction

	function automatic ls3_out_t solve_system(input ls3_in_t w);
		longint d1, d2, d3, l21, l31, l32, y1, y2, y3, z1, z2, z3, x0, x1, x2, t;
		ls3_out_t o;
		sat = 0;
		d1 = w.m00;
		l21 = q_div(w.m10, d1);
		l31 = q_div(w.m20, d1);
		d2 = q_sub(w.m11, q_mul(q_mul(l21, l21), d1));
		t = q_mul(q_mul(l21, l31), d1);
		l32 = q_div(q_sub(w.m21, t), d2);
		t = q_add(q_mul(q_mul(l31, l31), d1), q_mul(q_mul(l32, l32), d2));
		d3 = q_sub(w.m22, t);
		y1 = w.rhs_x;
		y2 = q_sub(w.rhs_y, q_mul(l21, y1));
		y3 = q_sub(q_sub(w.rhs_z, q_mul(l31, y1)), q_mul(l32, y2));
		z1 = q_div(y1, d1);
		z2 = q_div(y2, d2);
		z3 = q_div(y3, d3);
		x2 = z3;
		x1 = q_sub(z2, q_mul(l32, x2));
		x0 = q_sub(q_sub(z1, q_mul(l21, x1)), q_mul(l31, x2));
		o.sol_x = fix_t'(x0);
		o.sol_y = fix_t'(x1);
		o.sol_z = fix_t'(x2);
		o.singular = sat;
		return o;
	endfunction

	initial fail_count = 0;

	always @(posedge clk) begin
		ls3_out_t exp_w;
		int       errs;
		errs = 0;
		if (arst_n && start && !busy) begin
			solution_q.push_back(solve_system(operands));
		end
		if (arst_n && done) begin
			if (solution_q.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, result);
				errs++;
			end else begin
				exp_w = solution_q.pop_front();
				if (result.sol_x !== exp_w.sol_x) begin
					$display("%0t: sol_x expected %h actual %h", $time, exp_w.sol_x, result.sol_x);
					errs++;
				end
				if (result.sol_y !== exp_w.sol_y) begin
					$display("%0t: sol_y expected %h actual %h", $time, exp_w.sol_y, result.sol_y);
					errs++;
				end
				if (result.sol_z !== exp_w.sol_z) begin
					$display("%0t: sol_z expected %h actual %h", $time, exp_w.sol_z, result.sol_z);
					errs++;
				end
				if (result.singular !== exp_w.singular) begin
					$display("%0t: singular expected %b actual %b", $time, exp_w.singular,
						result.singular);
					errs++;
				end
			end
		end
		if (errs != 0) begin
			fail_count <= fail_count + errs;
		end
	end

endmodule

@@ verif/ldlt_solve_3x3_test.sv @@
`timescale 1ns / 1ps

module ldlt_solve_3x3_test;
	import ls3_pkg::*;

	localparam int LAT       = ls3_latency(FRAC_BITS_DEF);
	localparam int WDOG_MAX  = 20 * LAT + 1000;
	localparam int N_RANDOM  = 1630;
	localparam fix_t ONE     = fix_t'(1 << FRAC_BITS_DEF);
	localparam fix_t FMAX    = {1'b0, {(DW-1){1'b1}}};
	localparam fix_t FMIN    = {1'b1, {(DW-1){1'b0}}};

	logic     clk = 0;
	logic     arst_n = 0;
	logic     start = 0;
	logic     busy;
	ls3_in_t  operands = '0;
	logic     done;
	ls3_out_t result;
	int       fail_count;
	int       pending;
	int       idle_cycles = 0;

	always #1 clk = ~clk;

	ldlt_solve_3x3 i_dut (.clk, .arst_n, .start, .busy, .operands, .done, .result);

	ldlt_solve_3x3_checker i_chk (.clk, .arst_n, .start, .busy, .operands, .done, .result,
		.fail_count, .pending);

	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG_MAX) begin
			$display("ldlt_solve_3x3 regression: fail");
			$finish;
		end
	end

	// with gaps set, drop start for a random gap first, then hold the word until it is taken
	task automatic send_word(input ls3_in_t w, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 13) : 0;
		if (gap != 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		operands <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic fix_t pick_value(input int kind);
		case (kind)
			0: return fix_t'($urandom);
			1: return fix_t'($urandom_range(0, 7) << FRAC_BITS_DEF) - fix_t'(3 << FRAC_BITS_DEF);
			2: return fix_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			3: return FMAX;
			4: return FMIN;
			default: return '0;
		endcase
	endfunction

	// mostly systems with bounded off-diagonal terms and a nonzero diagonal; with noise set, random content
	function automatic ls3_in_t make_system(input bit noise);
		ls3_in_t w;
		int k;
		k = noise ? 0 : 2;
		w.m10 = pick_value(noise ? $urandom_range(0, 5) : k);
		w.m20 = pick_value(noise ? $urandom_range(0, 5) : k);
		w.m21 = pick_value(noise ? $urandom_range(0, 5) : k);
		w.m00 = noise ? pick_value($urandom_range(0, 5))
			: fix_t'($urandom_range(1, 1 << 21)) * ($urandom_range(0, 1) ? 1 : -1);
		w.m11 = noise ? pick_value($urandom_range(0, 5)) : fix_t'($urandom_range(1, 1 << 21));
		w.m22 = noise ? pick_value($urandom_range(0, 5)) : fix_t'($urandom_range(1, 1 << 21));
		w.rhs_x = pick_value($urandom_range(0, 2));
		w.rhs_y = pick_value($urandom_range(0, 2));
		w.rhs_z = pick_value($urandom_range(0, 2));
		return w;
	endfunction

	ls3_in_t w;
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// identity, zero matrix, each zero pivot, extremes
		w = '{ONE, 0, 0, ONE, 0, ONE, ONE, -ONE, FMAX};
		send_word(w, 0);
		w = '0;
		send_word(w, 0);
		w = '{0, ONE, ONE, ONE, 0, ONE, ONE, ONE, ONE};
		send_word(w, 0);
		w = '{ONE, ONE, 0, ONE, 0, ONE, -ONE, ONE, ONE};
		send_word(w, 0);
		w = '{ONE, 0, ONE, ONE, 0, ONE, ONE, ONE, -ONE};
		send_word(w, 0);
		w = '{FMAX, FMAX, FMAX, FMAX, FMAX, FMAX, FMAX, FMAX, FMAX};
		send_word(w, 1);
		w = '{FMIN, FMIN, FMIN, FMIN, FMIN, FMIN, FMIN, FMIN, FMIN};
		send_word(w, 1);
		w = '{FMIN, FMAX, FMIN, FMAX, FMIN, FMAX, FMIN, FMAX, FMIN};
		send_word(w, 0);
		w = '{1, FMAX, FMIN, 1, FMAX, -1, FMAX, FMIN, 1};
		send_word(w, 0);
		w = '{-ONE, ONE / 2, -ONE / 4, 2 * ONE, ONE, 3 * ONE, 0, FMIN, FMAX};
		send_word(w, 1);
		w = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
		send_word(w, 0);
		// let the pipe drain completely once
		start <= 0;
		while (pending != 0) @(posedge clk);
		for (int i = 0; i < N_RANDOM; i++) begin
			send_word(make_system($urandom_range(0, 3) == 0), (i / 200) % 2 == 1);
		end
		start <= 0;
		while (pending != 0) @(posedge clk);
		repeat (LAT + 20) @(posedge clk);
		if (fail_count == 0) begin
			$display("ldlt_solve_3x3 regression: pass");
		end else begin
			$display("ldlt_solve_3x3 regression: fail");
		end
		$finish;
	end

endmodule
